// ===== rtl/core/pbt_pkg.sv =====
// ----------------------------------------------------------------------------
// pbt_pkg
// Shared types and constants for the pose breadcrumb trail.
// ----------------------------------------------------------------------------
package pbt_pkg;

    // default trail depth, entries
    localparam int TRAIL_DEPTH_DEF = 1024;

    localparam int POS_W  = 24;
    localparam int HEAD_W = 16;
    localparam int DIST_W = 16;
    localparam int ANG_W  = 15;
    localparam int OP_W   = POS_W + 1;   // difference of two positions
    localparam int SQ_W   = 2 * OP_W;    // square of one difference
    localparam int THR_W  = 2 * DIST_W;  // squared threshold

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // operating modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_RECORD = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_DIST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_ANGLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_DIST   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_ANGLE  = 3'd4;

    // register reset values
    localparam logic [1:0]        MODE_RST         = MODE_RECORD;
    localparam logic [DIST_W-1:0] RECORD_DIST_RST  = 16'd50;
    localparam logic [ANG_W-1:0]  RECORD_ANGLE_RST = 15'd1043;
    localparam logic [DIST_W-1:0] CLEAR_DIST_RST   = 16'd500;
    localparam logic [ANG_W-1:0]  CLEAR_ANGLE_RST  = 15'd1043;

    // one trail entry
    typedef struct packed {
        logic [HEAD_W-1:0]       heading;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] x;
    } t_pose;

endpackage

// ===== rtl/core/pbt_trail_mem.sv =====
// ----------------------------------------------------------------------------
// pbt_trail_mem
// Trail store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pbt_trail_mem #(
    parameter int DEPTH = pbt_pkg::TRAIL_DEPTH_DEF,
    parameter int AW    = $clog2(pbt_pkg::TRAIL_DEPTH_DEF)
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  pbt_pkg::t_pose i_wdata,
    input  logic           i_re,
    input  logic [AW-1:0]  i_raddr,
    output pbt_pkg::t_pose o_rdata
);

    pbt_pkg::t_pose r_mem [DEPTH];
    pbt_pkg::t_pose r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/pbt_sq_unit.sv =====
// ----------------------------------------------------------------------------
// pbt_sq_unit
// Shared squaring unit: registered square of a signed operand, one per cycle.
// ----------------------------------------------------------------------------
module pbt_sq_unit (
    input  logic                              i_clk,
    input  logic signed [pbt_pkg::OP_W-1:0]   i_op,
    output logic        [pbt_pkg::SQ_W-1:0]   o_sq
);

    logic signed [pbt_pkg::SQ_W-1:0] prod;
    logic        [pbt_pkg::SQ_W-1:0] r_sq;

    assign prod = i_op * i_op;

    always_ff @(posedge i_clk) begin
        r_sq <= unsigned'(prod);
    end

    assign o_sq = r_sq;

endmodule

// ===== rtl/core/pose_breadcrumb_trail.sv =====
// ----------------------------------------------------------------------------
// pose_breadcrumb_trail
// Stack of planar poses, recorded by distance/yaw and cleared back to a pose.
// ----------------------------------------------------------------------------
// One pose at a time; the input is not ready while an item is in work.
// Idle mode, clear mode with at most one entry and record mode on an empty
// trail go to the output step, the last via the push step. Otherwise the
// threshold is squared, then the top entry is read and its squared distance
// from the x and y differences is summed and judged. Record mode judges one
// entry and may push; clear mode goes on after each pop while more than one
// entry is left. The single squaring multiplier serves once for the squared
// threshold and twice per compared entry; the trail store has one registered
// read port. The output step stalls while an earlier result is unaccepted.
// The input is ready again the cycle after a result is loaded, so a result
// waits in the output register while the next pose is accepted. Configuration
// writes are taken every cycle; the trail store needs no clearing after reset.
// ----------------------------------------------------------------------------
module pose_breadcrumb_trail #(
    parameter int TRAIL_DEPTH = pbt_pkg::TRAIL_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream: [23:0] pos_x, [47:24] pos_y, [63:48] heading
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,
    // master stream: [0] recorded, [10:1] popped_count, [11] clearing_error,
    // [12] overflow, [23:13] trail_count
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pbt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pbt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW = $clog2(TRAIL_DEPTH);
    localparam int CW = $clog2(TRAIL_DEPTH + 1);
    localparam int SW = (CW > 11) ? CW : 11;
    localparam int SQ_W = pbt_pkg::SQ_W;
    localparam int THR_W = pbt_pkg::THR_W;

    typedef enum logic [3:0] {
        S_IDLE, S_PUSH, S_THR, S_THR2, S_RD, S_MEM, S_DY, S_ACC, S_DEC, S_OUT
    } t_state;

    // configuration registers
    logic [1:0]                  r_cfg_mode;
    logic [pbt_pkg::DIST_W-1:0]  r_rec_dist;
    logic [pbt_pkg::ANG_W-1:0]   r_rec_ang;
    logic [pbt_pkg::DIST_W-1:0]  r_clr_dist;
    logic [pbt_pkg::ANG_W-1:0]   r_clr_ang;

    // sequencer and item state
    t_state                      r_state;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_pops;
    logic [1:0]                  r_mode;
    pbt_pkg::t_pose              r_pose;
    logic [THR_W-1:0]            r_thr;
    logic [SQ_W-1:0]             r_d2;
    logic                        r_rec;
    logic                        r_err;
    logic                        r_ovf;
    logic                        r_m_tvalid;
    logic [23:0]                 r_m_tdata;

    logic                        s_acc;
    pbt_pkg::t_pose              in_pose;
    pbt_pkg::t_pose              top_pose;
    logic                        mem_we;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;
    logic signed [pbt_pkg::OP_W-1:0] sq_op;
    logic [SQ_W-1:0]             sq;
    logic [pbt_pkg::DIST_W-1:0]  thr_dist;
    logic [15:0]                 yaw_d;
    logic [16:0]                 yaw_mag;
    logic                        rec_want;
    logic                        clr_ok;
    logic                        clr_err;
    logic                        has_room;
    logic [SW-1:0]               pops_w;
    logic [SW-1:0]               count_w;
    logic [9:0]                  pops_sat;
    logic [10:0]                 count_sat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode <= pbt_pkg::MODE_RST;
            r_rec_dist <= pbt_pkg::RECORD_DIST_RST;
            r_rec_ang  <= pbt_pkg::RECORD_ANGLE_RST;
            r_clr_dist <= pbt_pkg::CLEAR_DIST_RST;
            r_clr_ang  <= pbt_pkg::CLEAR_ANGLE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pbt_pkg::REG_MODE:         r_cfg_mode <= i_cfg_data[1:0];
                pbt_pkg::REG_RECORD_DIST:  r_rec_dist <= i_cfg_data;
                pbt_pkg::REG_RECORD_ANGLE: r_rec_ang  <= i_cfg_data[14:0];
                pbt_pkg::REG_CLEAR_DIST:   r_clr_dist <= i_cfg_data;
                pbt_pkg::REG_CLEAR_ANGLE:  r_clr_ang  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign in_pose         = pbt_pkg::t_pose'(i_s_axis_tdata);

    // trail store
    assign has_room  = (r_count < CW'(TRAIL_DEPTH));
    assign mem_we    = (r_state == S_PUSH) && has_room;
    assign mem_re    = (r_state == S_RD);
    assign mem_raddr = AW'(r_count - CW'(1));

    pbt_trail_mem #(
        .DEPTH (TRAIL_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_pose),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (top_pose)
    );

    // operand of the shared squarer for each sequencer step
    assign thr_dist = (r_mode == pbt_pkg::MODE_CLEAR) ? r_clr_dist : r_rec_dist;

    always_comb begin
        case (r_state)
            S_THR:   sq_op = signed'({9'd0, thr_dist});
            S_MEM:   sq_op = {r_pose.x[23], r_pose.x} - {top_pose.x[23], top_pose.x};
            S_DY:    sq_op = {r_pose.y[23], r_pose.y} - {top_pose.y[23], top_pose.y};
            default: sq_op = '0;
        endcase
    end

    pbt_sq_unit u_sq (
        .i_clk (i_clk),
        .i_op  (sq_op),
        .o_sq  (sq)
    );

    // shortest wrapped yaw turn; half a turn counts as 32768
    assign yaw_d   = r_pose.heading - top_pose.heading;
    assign yaw_mag = (yaw_d > 16'd32768) ? 17'(17'h10000 - {1'b0, yaw_d}) : {1'b0, yaw_d};

    assign rec_want = (r_d2 > SQ_W'(r_thr)) || (yaw_mag > 17'(r_rec_ang));
    assign clr_ok   = (r_d2 < SQ_W'(r_thr)) && (yaw_mag < 17'(r_clr_ang));
    assign clr_err  = (r_d2 > {16'd0, r_thr, 2'b00});

    assign pops_w    = SW'(r_pops);
    assign count_w   = SW'(r_count);
    assign pops_sat  = (pops_w > SW'(1023)) ? 10'd1023 : pops_w[9:0];
    assign count_sat = (count_w > SW'(2047)) ? 11'd2047 : count_w[10:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            // the output step reloads the register itself
            if (r_m_tvalid && i_m_axis_tready && r_state != S_OUT) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_pose <= in_pose;
                        r_mode <= r_cfg_mode;
                        r_pops <= '0;
                        r_rec  <= 1'b0;
                        r_err  <= 1'b0;
                        r_ovf  <= 1'b0;
                        case (r_cfg_mode)
                            pbt_pkg::MODE_RECORD:
                                r_state <= (r_count == '0) ? S_PUSH : S_THR;
                            pbt_pkg::MODE_CLEAR:
                                r_state <= (r_count > CW'(1)) ? S_THR : S_OUT;
                            default:
                                r_state <= S_OUT;
                        endcase
                    end
                end
                S_PUSH: begin
                    if (has_room) begin
                        r_count <= r_count + CW'(1);
                        r_rec   <= 1'b1;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_THR:  r_state <= S_THR2;
                S_THR2: begin
                    r_thr   <= sq[THR_W-1:0];
                    r_state <= S_RD;
                end
                S_RD:  r_state <= S_MEM;
                S_MEM: r_state <= S_DY;
                S_DY: begin
                    r_d2    <= sq;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_d2    <= r_d2 + sq;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    if (r_mode == pbt_pkg::MODE_RECORD) begin
                        r_state <= rec_want ? S_PUSH : S_OUT;
                    end else if (clr_ok) begin
                        r_count <= r_count - CW'(1);
                        r_pops  <= r_pops + CW'(1);
                        r_state <= (r_count > CW'(2)) ? S_RD : S_OUT;
                    end else begin
                        r_err   <= clr_err;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_m_tvalid || i_m_axis_tready) begin
                        r_m_tdata  <= {count_sat, r_ovf, r_err, pops_sat, r_rec};
                        r_m_tvalid <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;

    // trail never grows past its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TRAIL_DEPTH))
        else $error("trail count beyond depth");

    // a pop in clear mode always leaves at least one entry
    a_keep_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC && r_mode != pbt_pkg::MODE_RECORD && clr_ok)
        |-> r_count > CW'(1))
        else $error("clear would empty the trail");

    // a new result only appears out of the output step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == S_OUT))
        else $error("result raised outside output step");

    // a result never reports both a push and pops
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[0] && o_m_axis_tdata[10:1] != 10'd0))
        else $error("push and pop in one result");

    // the trail store is written only with a free slot
    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> r_count <= CW'(TRAIL_DEPTH) && r_rec)
        else $error("write without room");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for pose_breadcrumb_trail. Poses go in on the slave
// stream and results are checked field by field against a local predictor of
// the trail stack. Directed cases cover the record and clear thresholds,
// modes and register masking. Random walks then record and clear trails
// under random thresholds.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_W        = pbt_pkg::POS_W;
    localparam int HEAD_W       = pbt_pkg::HEAD_W;
    localparam int DIST_W       = pbt_pkg::DIST_W;
    localparam int ANG_W        = pbt_pkg::ANG_W;
    localparam int CFG_IDX_W    = pbt_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = pbt_pkg::CFG_DATA_W;
    localparam int DEPTH        = pbt_pkg::TRAIL_DEPTH_DEF;
    localparam int QUIET_LIMIT  = 24000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_GAP      = 8;
    localparam int HALF_TURN    = 32768;
    localparam int FULL_TURN    = 65536;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [10:0] trail_count;
        logic        overflow;
        logic        clearing_error;
        logic [9:0]  popped_count;
        logic        recorded;
    } t_crumb_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [63:0]           i_s_axis_tdata = '0;  // [23:0] x, [47:24] y, [63:48] heading
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [23:0]           o_m_axis_tdata;       // [0] rec, [10:1] pops, [11] err,
                                                 // [12] ovf, [23:13] count
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    pose_breadcrumb_trail #(
        .TRAIL_DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predicted block state
    logic [1:0]        cfg_mode;
    logic [DIST_W-1:0] cfg_rec_dist;
    logic [ANG_W-1:0]  cfg_rec_ang;
    logic [DIST_W-1:0] cfg_clr_dist;
    logic [ANG_W-1:0]  cfg_clr_ang;
    pbt_pkg::t_pose    crumbs [DEPTH];
    int                crumb_count;

    t_crumb_result pending_results [$];
    int            errors = 0;
    bit            calm = 1'b0;  // no idling on either side while set

    // last pose sent, the random walks continue from it
    logic signed [POS_W-1:0] walk_x = '0;
    logic signed [POS_W-1:0] walk_y = '0;
    logic [HEAD_W-1:0]       walk_h = '0;

    function automatic longint dist_sq(pbt_pkg::t_pose a, pbt_pkg::t_pose b);
        longint dx, dy;
        dx = longint'($signed(a.x)) - longint'($signed(b.x));
        dy = longint'($signed(a.y)) - longint'($signed(b.y));
        return dx * dx + dy * dy;
    endfunction

    // shortest wrapped turn, half a turn counts as HALF_TURN
    function automatic int yaw_turn(logic [HEAD_W-1:0] a, logic [HEAD_W-1:0] b);
        logic [HEAD_W-1:0] d;
        d = a - b;
        return (int'(d) > HALF_TURN) ? FULL_TURN - int'(d) : int'(d);
    endfunction

    function automatic t_crumb_result advance_trail(pbt_pkg::t_pose p);
        t_crumb_result  r;
        longint         lim, d2;
        pbt_pkg::t_pose top;
        int             pops;
        bit             want, busy;
        r = '0;
        pops = 0;
        if (cfg_mode == pbt_pkg::MODE_RECORD) begin
            want = 1'b1;
            if (crumb_count > 0) begin
                top = crumbs[crumb_count - 1];
                lim = longint'(cfg_rec_dist) * longint'(cfg_rec_dist);
                want = (dist_sq(p, top) > lim) ||
                       (yaw_turn(p.heading, top.heading) > int'(cfg_rec_ang));
            end
            if (want && crumb_count < DEPTH) begin
                crumbs[crumb_count] = p;
                crumb_count++;
                r.recorded = 1'b1;
            end else if (want) begin
                r.overflow = 1'b1;
            end
        end else if (cfg_mode == pbt_pkg::MODE_CLEAR) begin
            lim = longint'(cfg_clr_dist) * longint'(cfg_clr_dist);
            busy = 1'b1;
            while (busy && crumb_count > 1) begin
                top = crumbs[crumb_count - 1];
                d2 = dist_sq(p, top);
                if (d2 < lim && yaw_turn(p.heading, top.heading) < int'(cfg_clr_ang)) begin
                    crumb_count--;
                    pops++;
                end else begin
                    r.clearing_error = (d2 > 4 * lim);
                    busy = 1'b0;
                end
            end
        end
        r.popped_count = (pops > 1023) ? 10'd1023 : pops[9:0];
        r.trail_count = (crumb_count > 2047) ? 11'd2047 : crumb_count[10:0];
        return r;
    endfunction

    function automatic int field_miss(string field, int due, int seen);
        if (due == seen)
            return 0;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, due, seen);
        return 1;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_dist();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 16'hFFFF;
            2: return CFG_DATA_W'($urandom_range(1, 64));
            3: return CFG_DATA_W'($urandom_range(65, 4000));
            default: return CFG_DATA_W'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_angle();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 16'h7FFF;
            2: return CFG_DATA_W'($urandom_range(1, 200));
            3: return CFG_DATA_W'($urandom_range(201, 4000));
            default: return CFG_DATA_W'($urandom_range(0, 32767));
        endcase
    endfunction

    // one pose transaction; valid stays high afterwards for back-to-back items
    task automatic send_pose(input logic signed [POS_W-1:0] x,
                             input logic signed [POS_W-1:0] y,
                             input logic [HEAD_W-1:0] h);
        pbt_pkg::t_pose p;
        int             gap;
        p.x = x;
        p.y = y;
        p.heading = h;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= p;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pending_results = {pending_results, advance_trail(p)};
        walk_x = x;
        walk_y = y;
        walk_h = h;
    endtask

    task automatic await_drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            pbt_pkg::REG_MODE:         cfg_mode = val[1:0];
            pbt_pkg::REG_RECORD_DIST:  cfg_rec_dist = val;
            pbt_pkg::REG_RECORD_ANGLE: cfg_rec_ang = val[ANG_W-1:0];
            pbt_pkg::REG_CLEAR_DIST:   cfg_clr_dist = val;
            pbt_pkg::REG_CLEAR_ANGLE:  cfg_clr_ang = val[ANG_W-1:0];
            default: ;
        endcase
    endtask

    // waits until the block is idle, then rewrites every register
    task automatic program_regs(input logic [CFG_DATA_W-1:0] mode_v, rd, ra, cd, ca);
        await_drain();
        write_reg(pbt_pkg::REG_MODE, mode_v);
        write_reg(pbt_pkg::REG_RECORD_DIST, rd);
        write_reg(pbt_pkg::REG_RECORD_ANGLE, ra);
        write_reg(pbt_pkg::REG_CLEAR_DIST, cd);
        write_reg(pbt_pkg::REG_CLEAR_ANGLE, ca);
        i_cfg_valid <= 1'b0;
    endtask

    // starts from an empty trail, so it runs first
    task automatic test_clear_cases();
        program_regs(CFG_DATA_W'(pbt_pkg::MODE_CLEAR), pbt_pkg::RECORD_DIST_RST,
                     CFG_DATA_W'(pbt_pkg::RECORD_ANGLE_RST), pbt_pkg::CLEAR_DIST_RST,
                     CFG_DATA_W'(pbt_pkg::CLEAR_ANGLE_RST));
        send_pose(5, 5, 5);                    // empty trail
        program_regs(CFG_DATA_W'(pbt_pkg::MODE_RECORD), 0, 0, pbt_pkg::CLEAR_DIST_RST,
                     CFG_DATA_W'(pbt_pkg::CLEAR_ANGLE_RST));
        send_pose(0, 0, 0);
        program_regs(CFG_DATA_W'(pbt_pkg::MODE_CLEAR), 0, 0, pbt_pkg::CLEAR_DIST_RST,
                     CFG_DATA_W'(pbt_pkg::CLEAR_ANGLE_RST));
        send_pose(8388607, 8388607, 16'h8000); // single entry: no pop, no error
        program_regs(CFG_DATA_W'(pbt_pkg::MODE_RECORD), 0, 0, pbt_pkg::CLEAR_DIST_RST,
                     CFG_DATA_W'(pbt_pkg::CLEAR_ANGLE_RST));
        send_pose(300, 400, 0);
        program_regs(CFG_DATA_W'(pbt_pkg::MODE_CLEAR), 0, 0, pbt_pkg::CLEAR_DIST_RST,
                     CFG_DATA_W'(pbt_pkg::CLEAR_ANGLE_RST));
        send_pose(0, 0, 0);                    // distance exactly at threshold
        send_pose(300, 400, HEAD_W'(pbt_pkg::CLEAR_ANGLE_RST));  // angle exactly at threshold
        send_pose(1300, 400, 0);               // exactly twice the distance
        send_pose(1301, 400, 0);               // just beyond: error
        send_pose(300, 401, HEAD_W'(int'(pbt_pkg::CLEAR_ANGLE_RST) - 1));
        send_pose(0, 0, 0);
    endtask

    task automatic test_record_thresholds();
        program_regs(CFG_DATA_W'(pbt_pkg::MODE_RECORD), pbt_pkg::RECORD_DIST_RST,
                     CFG_DATA_W'(pbt_pkg::RECORD_ANGLE_RST), pbt_pkg::CLEAR_DIST_RST,
                     CFG_DATA_W'(pbt_pkg::CLEAR_ANGLE_RST));
        send_pose(1000, -2000, 100);
        send_pose(1000, -2000, 100);
        send_pose(1050, -2000, 100);           // 50 away, not beyond
        send_pose(1030, -1960, 100);           // 30/40/50 triangle
        send_pose(1051, -2000, 100);
        send_pose(1051, -2000, 100 + 1043);
        send_pose(1051, -2000, 100 + 1044);
        send_pose(1051, -2000, 101);
        send_pose(1051, -2000, 1144 + HALF_TURN);
        send_pose(1051, -2000, 16'hFFFF);
        send_pose(1051, -2000, 500);           // wraps through zero
    endtask

    task automatic test_modes_and_masking();
        int n;
        program_regs(CFG_DATA_W'(pbt_pkg::MODE_IDLE), pbt_pkg::RECORD_DIST_RST,
                     CFG_DATA_W'(pbt_pkg::RECORD_ANGLE_RST), pbt_pkg::CLEAR_DIST_RST,
                     CFG_DATA_W'(pbt_pkg::CLEAR_ANGLE_RST));
        send_pose(123, -456, 789);
        // all-ones writes: mode lands on the spare code, thresholds get masked
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pose(-1, -1, 16'hFFFF);
        await_drain();
        for (n = 1; n <= 3; n++)
            write_reg(CFG_IDX_W'(int'(pbt_pkg::REG_CLEAR_ANGLE) + n),
                      CFG_DATA_W'($urandom()));
        i_cfg_valid <= 1'b0;
        send_pose(7, 7, 7);
        program_regs(16'hFFFD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pose(walk_x, walk_y, HEAD_W'(int'(walk_h) + HALF_TURN));
        send_pose(POS_W'(walk_x + 1), walk_y, HEAD_W'(int'(walk_h) + HALF_TURN - 1));
        program_regs(CFG_DATA_W'(pbt_pkg::MODE_RECORD), 0, 0, pbt_pkg::CLEAR_DIST_RST,
                     CFG_DATA_W'(pbt_pkg::CLEAR_ANGLE_RST));
        send_pose(-8388608, 8388607, 0);
        send_pose(8388607, -8388608, 16'hFFFF);
        send_pose(8388607, -8388608, 16'hFFFF);
    endtask

    task automatic test_random_walks();
        int             span, turn, dx, dy, dh, k, cd, ca;
        pbt_pkg::t_pose mark;
        for (int leg = 0; leg < 7; leg++) begin
            calm = ($urandom_range(0, 3) == 0);
            program_regs(CFG_DATA_W'(pbt_pkg::MODE_RECORD), pick_dist(), pick_angle(),
                         cfg_clr_dist, CFG_DATA_W'(cfg_clr_ang));
            repeat (55) begin
                span = int'(cfg_rec_dist) + 2;
                turn = int'(cfg_rec_ang) + 2;
                dx = int'($urandom_range(0, 2 * span)) - span;
                dy = int'($urandom_range(0, 2 * span)) - span;
                dh = int'($urandom_range(0, 2 * turn)) - turn;
                if ($urandom_range(0, 99) < 15)
                    send_pose(POS_W'($urandom()), POS_W'($urandom()), HEAD_W'($urandom()));
                else
                    send_pose(POS_W'(int'(walk_x) + dx), POS_W'(int'(walk_y) + dy),
                              HEAD_W'(int'(walk_h) + dh));
            end
            // half the legs clear with thresholds a few record steps wide
            if ($urandom_range(0, 1) == 1) begin
                cd = int'(cfg_rec_dist) * 4 + 10;
                ca = int'(cfg_rec_ang) * 4 + 10;
                program_regs(CFG_DATA_W'(pbt_pkg::MODE_CLEAR), cfg_rec_dist,
                             CFG_DATA_W'(cfg_rec_ang),
                             CFG_DATA_W'((cd > 65535) ? 65535 : cd),
                             CFG_DATA_W'((ca > 32767) ? 32767 : ca));
            end else begin
                program_regs(CFG_DATA_W'(pbt_pkg::MODE_CLEAR), cfg_rec_dist,
                             CFG_DATA_W'(cfg_rec_ang), pick_dist(), pick_angle());
            end
            repeat (35) begin
                if (crumb_count == 0 || $urandom_range(0, 99) < 15) begin
                    send_pose(POS_W'($urandom()), POS_W'($urandom()), HEAD_W'($urandom()));
                end else begin
                    k = crumb_count - 1 -
                        int'($urandom_range(0, (crumb_count > 25) ? 24 : crumb_count - 1));
                    mark = crumbs[k];
                    span = int'(cfg_clr_dist) + 1;
                    if ($urandom_range(0, 4) == 0)
                        span = span * 3;
                    turn = int'(cfg_clr_ang) + 1;
                    dx = int'($urandom_range(0, 2 * span)) - span;
                    dy = int'($urandom_range(0, 2 * span)) - span;
                    dh = int'($urandom_range(0, 2 * turn)) - turn;
                    send_pose(POS_W'(int'(mark.x) + dx), POS_W'(int'(mark.y) + dy),
                              HEAD_W'(int'(mark.heading) + dh));
                end
            end
            if (leg % 3 == 2) begin
                program_regs(CFG_DATA_W'(($urandom_range(0, 1) == 1) ? pbt_pkg::MODE_IDLE
                                                                     : MODE_SPARE),
                             cfg_rec_dist, CFG_DATA_W'(cfg_rec_ang), cfg_clr_dist,
                             CFG_DATA_W'(cfg_clr_ang));
                repeat (10)
                    send_pose(POS_W'($urandom()), POS_W'($urandom()), HEAD_W'($urandom()));
            end
        end
        calm = 1'b0;
    endtask

    always @(posedge i_clk) begin : take_result
        t_crumb_result due, seen;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen = t_crumb_result'(o_m_axis_tdata);
            if (pending_results.size() == 0) begin
                $display("%0t: result %h with nothing expected", $time, o_m_axis_tdata);
                errors++;
            end else begin
                due = pending_results.pop_front();
                errors += field_miss("recorded", int'(due.recorded), int'(seen.recorded));
                errors += field_miss("popped_count", int'(due.popped_count),
                                     int'(seen.popped_count));
                errors += field_miss("clearing_error", int'(due.clearing_error),
                                     int'(seen.clearing_error));
                errors += field_miss("overflow", int'(due.overflow), int'(seen.overflow));
                errors += field_miss("trail_count", int'(due.trail_count),
                                     int'(seen.trail_count));
            end
        end
    end

    // result side: random stall before each transaction
    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        cfg_mode = pbt_pkg::MODE_RST;
        cfg_rec_dist = pbt_pkg::RECORD_DIST_RST;
        cfg_rec_ang = pbt_pkg::RECORD_ANGLE_RST;
        cfg_clr_dist = pbt_pkg::CLEAR_DIST_RST;
        cfg_clr_ang = pbt_pkg::CLEAR_ANGLE_RST;
        crumb_count = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_clear_cases();
        test_record_thresholds();
        test_modes_and_masking();
        test_random_walks();
        await_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/pbt_pkg.sv
rtl/core/pbt_trail_mem.sv
rtl/core/pbt_sq_unit.sv
rtl/core/pose_breadcrumb_trail.sv
sim/tb_top.sv
